// File: rtl/crv_pkg.sv
// Shared types, constants and the CRC shift step for the CRC-32 region verifier.
// Used by every module of the block; depends on nothing.
package crv_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned COL_IDX_W  = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned M_FIELDS_W = CRC_W + STATUS_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [CRC_W-1:0] POLY_DEFAULT = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] INIT_DEFAULT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] TOP_BIT      = {1'b1, {(CRC_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY     = 3'd0,
        CFG_INIT     = 3'd1,
        CFG_EXPECTED = 3'd2,
        CFG_FLASH    = 3'd3,
        CFG_OFFSET   = 3'd4,
        CFG_LENGTH   = 3'd5
    } crv_cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK  = 2'd0,
        STATUS_BAD = 2'd1,
        STATUS_NA  = 2'd2
    } crv_status_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_poly;
        logic [CRC_W-1:0] crc_init;
        logic [CRC_W-1:0] expected_crc;
        logic [CRC_W-1:0] flash_size;
        logic [CRC_W-1:0] region_offset;
        logic [CRC_W-1:0] region_length;
    } crv_cfg_t;

    typedef struct packed {
        logic             reload;
        logic             poly_write;
        logic [CRC_W-1:0] init_value;
    } crv_cfg_evt_t;

    typedef logic [CRC_W-1:0][CRC_W-1:0] crv_cols_t;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c,
                                                  input logic [CRC_W-1:0] poly);
        crc_step = {c[CRC_W-2:0], 1'b0} ^ (c[CRC_W-1] ? poly : '0);
    endfunction

endpackage

// File: rtl/crv_cfg_regs.sv
// Configuration register file and region bounds check.
// Depends on crv_pkg.
module crv_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [crv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crv_pkg::CRC_W-1:0]           cfg_wdata,
    output crv_pkg::crv_cfg_t                   cfg,
    output crv_pkg::crv_cfg_evt_t               evt,
    output logic                                in_range
);

    crv_pkg::crv_cfg_t cfg_reg;
    crv_pkg::crv_cfg_t cfg_next;
    logic              hit;

    always_comb begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_we) begin
            hit = 1'b1;
            unique case (crv_pkg::crv_cfg_idx_t'(cfg_index))
                crv_pkg::CFG_POLY:     cfg_next.crc_poly      = cfg_wdata;
                crv_pkg::CFG_INIT:     cfg_next.crc_init      = cfg_wdata;
                crv_pkg::CFG_EXPECTED: cfg_next.expected_crc  = cfg_wdata;
                crv_pkg::CFG_FLASH:    cfg_next.flash_size    = cfg_wdata;
                crv_pkg::CFG_OFFSET:   cfg_next.region_offset = cfg_wdata;
                crv_pkg::CFG_LENGTH:   cfg_next.region_length = cfg_wdata;
                default:               hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_poly      <= crv_pkg::POLY_DEFAULT;
            cfg_reg.crc_init      <= crv_pkg::INIT_DEFAULT;
            cfg_reg.expected_crc  <= '0;
            cfg_reg.flash_size    <= '0;
            cfg_reg.region_offset <= '0;
            cfg_reg.region_length <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg            = cfg_reg;
    assign evt.reload     = hit;
    assign evt.poly_write = cfg_we && (cfg_index == crv_pkg::CFG_POLY);
    assign evt.init_value = cfg_next.crc_init;

    assign in_range = (cfg_reg.flash_size != '0) &&
                      (cfg_reg.region_offset <= cfg_reg.flash_size) &&
                      (cfg_reg.region_length <= (cfg_reg.flash_size - cfg_reg.region_offset));

endmodule

// File: rtl/crv_col_gen.sv
// Builds the 32 columns of the word-wide CRC matrix, one shift step per cycle,
// after reset and after every polynomial write. Depends on crv_pkg.
module crv_col_gen (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [crv_pkg::CRC_W-1:0]   poly,
    input  logic                        restart,
    output crv_pkg::crv_cols_t          cols,
    output logic                        cols_ready
);

    localparam logic [crv_pkg::COL_IDX_W-1:0] LAST_COL = '1;

    logic                              busy_reg;
    logic [crv_pkg::COL_IDX_W-1:0]     cnt_reg;
    logic [crv_pkg::CRC_W-1:0]         v_reg;
    logic [crv_pkg::CRC_W-1:0]         v_next;
    crv_pkg::crv_cols_t                cols_reg;

    assign v_next = crv_pkg::crc_step(v_reg, poly);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            v_reg    <= crv_pkg::TOP_BIT;
        end else if (restart) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            v_reg    <= crv_pkg::TOP_BIT;
        end else if (busy_reg) begin
            v_reg <= v_next;
            if (cnt_reg == LAST_COL) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn && !restart && busy_reg) begin
            cols_reg[cnt_reg] <= v_next;
        end
    end

    assign cols       = cols_reg;
    assign cols_ready = !busy_reg;

`ifndef SYNTHESIS
    a_sweep_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (cnt_reg == LAST_COL) && !restart) |=> !busy_reg)
        else $error("column sweep did not finish after the last column");
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && !restart) |=> (!busy_reg && $stable(cols_reg)))
        else $error("columns changed without a polynomial write");
`endif

endmodule

// File: rtl/crv_datapath.sv
// Input register, word-wide CRC update, status check and result register.
// Depends on crv_pkg; columns from crv_col_gen, settings from crv_cfg_regs.
module crv_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  crv_pkg::crv_cols_t                cols,
    input  logic                              cols_ready,
    input  crv_pkg::crv_cfg_t                 cfg,
    input  crv_pkg::crv_cfg_evt_t             evt,
    input  logic                              in_range,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crv_pkg::CRC_W-1:0]         s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crv_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                          in_valid_reg;
    logic [crv_pkg::CRC_W-1:0]     in_word_reg;
    logic                          in_last_reg;
    logic [crv_pkg::CRC_W-1:0]     acc_reg;
    logic                          out_valid_reg;
    logic [crv_pkg::CRC_W-1:0]     out_crc_reg;
    crv_pkg::crv_status_t          out_status_reg;

    logic                          out_free;
    logic                          in_fire;
    logic                          s_accept;
    logic [crv_pkg::CRC_W-1:0]     x;
    logic [crv_pkg::CRC_W-1:0]     crc;
    crv_pkg::crv_status_t          status;

    assign out_free = !out_valid_reg || m_tready;
    assign in_fire  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = cols_ready && (!in_valid_reg || in_fire);
    assign s_accept = s_tvalid && s_tready;

    assign x = acc_reg ^ in_word_reg;

    always_comb begin
        crc = '0;
        for (int j = 0; j < crv_pkg::CRC_W; j++) begin
            crc = crc ^ (x[j] ? cols[j] : '0);
        end
    end

    always_comb begin
        if (!in_range) begin
            status = crv_pkg::STATUS_NA;
        end else if (crc == cfg.expected_crc) begin
            status = crv_pkg::STATUS_OK;
        end else begin
            status = crv_pkg::STATUS_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= crv_pkg::INIT_DEFAULT;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (in_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (evt.reload) begin
                acc_reg <= evt.init_value;
            end else if (in_fire) begin
                acc_reg <= in_last_reg ? cfg.crc_init : crc;
            end
            if (in_fire && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_fire && in_last_reg) begin
            out_crc_reg    <= crc;
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{crv_pkg::M_PAD_W{1'b0}}, out_status_reg, out_crc_reg};

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last_reg) |=> m_tvalid)
        else $error("last item did not produce a result");
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        !cols_ready |-> !s_tready)
        else $error("item accepted while the CRC columns are being built");
    a_plain_keeps_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !in_last_reg && m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result lost while a plain item passed");
`endif

endmodule

// File: rtl/crc32_region_verifier_unit.sv
// CRC-32 region verifier, top level.
// Depends on crv_pkg, crv_cfg_regs, crv_col_gen and crv_datapath.
//
// Input channel s_*: one 32-bit flash word per item, s_tlast marks the last
// word of the region. Result channel m_*: one item per region, the CRC of all
// its words and a status (ok, bad, or region outside flash).
// Configuration: cfg_we writes cfg_wdata to register cfg_index at the clock
// edge; each write to a defined register reloads the accumulator from the start value.
// A last word accepted into the input register moves on to the result register and
// shows at m_tvalid from there. Throughput: one word per cycle while s_tready is high,
// set by the matrix update of the accumulator (an AND-XOR tree over 32 stored columns).
// After reset and after each polynomial write, the 32 columns are rebuilt one
// per cycle; s_tready is low until they are all rebuilt.
// Reset sets the settings and the accumulator to their defaults and empties both stages.
// When the receiver stalls, the result register holds; non-last words keep
// flowing, and the next last word waits in the input register until the
// result slot is free, which then holds s_tready low.
module crc32_region_verifier_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [crv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crv_pkg::CRC_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crv_pkg::CRC_W-1:0]         s_tdata,   // data_word[31:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crv_pkg::M_TDATA_W-1:0]     m_tdata    // crc_value[31:0], status[33:32]
);

    crv_pkg::crv_cfg_t      cfg;
    crv_pkg::crv_cfg_evt_t  evt;
    crv_pkg::crv_cols_t     cols;
    logic                   in_range;
    logic                   cols_ready;

    crv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .evt       (evt),
        .in_range  (in_range)
    );

    crv_col_gen u_cols (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .poly       (cfg.crc_poly),
        .restart    (evt.poly_write),
        .cols       (cols),
        .cols_ready (cols_ready)
    );

    crv_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cols       (cols),
        .cols_ready (cols_ready),
        .cfg        (cfg),
        .evt        (evt),
        .in_range   (in_range),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for crc32_region_verifier_unit: drives flash words and register writes,
// predicts each region's CRC and status, and checks every result item.
// Depends on crv_pkg and the crc32_region_verifier_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [crv_pkg::CRC_W-1:0] crc_value;
        crv_pkg::crv_status_t      status;
    } region_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [crv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [crv_pkg::CRC_W-1:0]      cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [crv_pkg::CRC_W-1:0]      s_tdata   = '0;   // data_word[31:0]
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [crv_pkg::M_TDATA_W-1:0]  m_tdata;          // crc_value[31:0], status[33:32]

    crv_pkg::crv_cfg_t         cfg_shadow;
    logic [crv_pkg::CRC_W-1:0] acc_shadow;
    region_result_t            region_results_q[$];
    int                        error_count    = 0;
    int                        words_sent     = 0;
    int                        src_idle_pct   = 0;
    int                        sink_stall_pct = 0;
    int                        sink_hold_left = 0;

    crc32_region_verifier_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [crv_pkg::CRC_W-1:0] crc_fold_word(
        input logic [crv_pkg::CRC_W-1:0] acc,
        input logic [crv_pkg::CRC_W-1:0] word,
        input logic [crv_pkg::CRC_W-1:0] poly);
        logic [crv_pkg::CRC_W-1:0] c;
        c = acc ^ word;
        for (int b = 0; b < crv_pkg::CRC_W; b++) begin
            c = c[crv_pkg::CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic crv_pkg::crv_status_t region_verdict(
        input logic [crv_pkg::CRC_W-1:0] crc);
        logic in_flash;
        in_flash = (cfg_shadow.flash_size != '0) &&
                   (cfg_shadow.region_offset <= cfg_shadow.flash_size) &&
                   (cfg_shadow.region_length <=
                    cfg_shadow.flash_size - cfg_shadow.region_offset);
        if (!in_flash) begin
            return crv_pkg::STATUS_NA;
        end
        return (crc == cfg_shadow.expected_crc) ? crv_pkg::STATUS_OK : crv_pkg::STATUS_BAD;
    endfunction

    function automatic logic [crv_pkg::CRC_W-1:0] pick_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return crv_pkg::CRC_W'($urandom_range(64));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [crv_pkg::CRC_W-1:0] pick_cfg_value(
        input logic [crv_pkg::CFG_IDX_W-1:0] idx);
        case (idx)
            crv_pkg::CFG_POLY: begin
                if ($urandom_range(2) == 0) begin
                    return crv_pkg::POLY_DEFAULT;
                end
                return pick_word();
            end
            crv_pkg::CFG_EXPECTED: return $urandom();
            crv_pkg::CFG_FLASH: begin
                case ($urandom_range(4))
                    0: return '0;
                    1: return '1;
                    2: return crv_pkg::CRC_W'($urandom_range(4096, 1));
                    default: return $urandom();
                endcase
            end
            crv_pkg::CFG_OFFSET: begin
                if ($urandom_range(3) != 0) begin
                    return $urandom_range(cfg_shadow.flash_size);
                end
                return pick_word();
            end
            crv_pkg::CFG_LENGTH: begin
                if ($urandom_range(3) != 0 &&
                    cfg_shadow.region_offset <= cfg_shadow.flash_size) begin
                    return $urandom_range(cfg_shadow.flash_size - cfg_shadow.region_offset);
                end
                return pick_word();
            end
            default: return pick_word();
        endcase
    endfunction

    task automatic write_reg(input logic [crv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [crv_pkg::CRC_W-1:0] value);
        logic known;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        known = 1'b1;
        case (idx)
            crv_pkg::CFG_POLY:     cfg_shadow.crc_poly      = value;
            crv_pkg::CFG_INIT:     cfg_shadow.crc_init      = value;
            crv_pkg::CFG_EXPECTED: cfg_shadow.expected_crc  = value;
            crv_pkg::CFG_FLASH:    cfg_shadow.flash_size    = value;
            crv_pkg::CFG_OFFSET:   cfg_shadow.region_offset = value;
            crv_pkg::CFG_LENGTH:   cfg_shadow.region_length = value;
            default:               known = 1'b0;
        endcase
        if (known) begin
            acc_shadow = cfg_shadow.crc_init;
        end
    endtask

    task automatic write_all_regs();
        write_reg(crv_pkg::CFG_POLY,     pick_cfg_value(crv_pkg::CFG_POLY));
        write_reg(crv_pkg::CFG_INIT,     pick_cfg_value(crv_pkg::CFG_INIT));
        write_reg(crv_pkg::CFG_EXPECTED, pick_cfg_value(crv_pkg::CFG_EXPECTED));
        write_reg(crv_pkg::CFG_FLASH,    pick_cfg_value(crv_pkg::CFG_FLASH));
        write_reg(crv_pkg::CFG_OFFSET,   pick_cfg_value(crv_pkg::CFG_OFFSET));
        write_reg(crv_pkg::CFG_LENGTH,   pick_cfg_value(crv_pkg::CFG_LENGTH));
    endtask

    task automatic push_word(input logic [crv_pkg::CRC_W-1:0] word, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        words_sent++;
        acc_shadow = crc_fold_word(acc_shadow, word, cfg_shadow.crc_poly);
        if (last) begin
            region_results_q.push_back('{acc_shadow, region_verdict(acc_shadow)});
            acc_shadow = cfg_shadow.crc_init;
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (region_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_region(input int len);
        for (int i = 0; i < len; i++) begin
            push_word($urandom(), i == len - 1);
        end
    endtask

    task automatic send_matched_region(input int len);
        logic [crv_pkg::CRC_W-1:0] words[$];
        logic [crv_pkg::CRC_W-1:0] crc;
        wait_results_drained();
        crc = cfg_shadow.crc_init;
        for (int i = 0; i < len; i++) begin
            words.push_back($urandom());
            crc = crc_fold_word(crc, words[i], cfg_shadow.crc_poly);
        end
        write_reg(crv_pkg::CFG_EXPECTED, crc);
        foreach (words[i]) begin
            push_word(words[i], i == words.size() - 1);
        end
    endtask

    task automatic check_bounds(input logic [crv_pkg::CRC_W-1:0] flash,
                                input logic [crv_pkg::CRC_W-1:0] offset,
                                input logic [crv_pkg::CRC_W-1:0] length);
        wait_results_drained();
        write_reg(crv_pkg::CFG_FLASH, flash);
        write_reg(crv_pkg::CFG_OFFSET, offset);
        write_reg(crv_pkg::CFG_LENGTH, length);
        push_word($urandom(), 1'b1);
    endtask

    task automatic test_reset_defaults();
        push_word('0, 1'b1);
        push_word('1, 1'b1);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'hA5A5_A5A5, 1'b1);
    endtask

    task automatic test_region_bounds();
        check_bounds(32'd1000, 32'd0, 32'd1000);
        check_bounds(32'd1000, 32'd1000, 32'd0);
        check_bounds(32'd1000, 32'd1001, 32'd0);
        check_bounds(32'd1000, 32'd500, 32'd501);
        check_bounds('1, '0, '1);
        check_bounds('1, '1, 32'd1);
        check_bounds('0, '0, '0);
    endtask

    task automatic test_crc_match();
        wait_results_drained();
        write_reg(crv_pkg::CFG_FLASH, 32'h0010_0000);
        write_reg(crv_pkg::CFG_OFFSET, 32'h0000_0100);
        write_reg(crv_pkg::CFG_LENGTH, 32'h0000_0400);
        send_matched_region(3);
        wait_results_drained();
        write_reg(crv_pkg::CFG_POLY, '0);
        write_reg(crv_pkg::CFG_INIT, '0);
        send_matched_region(1);
        wait_results_drained();
        write_reg(crv_pkg::CFG_POLY, '1);
        write_reg(crv_pkg::CFG_INIT, '1);
        send_matched_region(2);
        wait_results_drained();
        write_reg(crv_pkg::CFG_EXPECTED, ~cfg_shadow.expected_crc);
        send_region(1);
        wait_results_drained();
        write_reg(crv_pkg::CFG_POLY, crv_pkg::POLY_DEFAULT);
    endtask

    task automatic test_reload_rules();
        push_word($urandom(), 1'b0);
        push_word($urandom(), 1'b0);
        wait_results_drained();
        for (int i = int'(crv_pkg::CFG_LENGTH) + 1; i < (1 << crv_pkg::CFG_IDX_W); i++) begin
            write_reg(crv_pkg::CFG_IDX_W'(i), $urandom());
        end
        push_word($urandom(), 1'b1);
        push_word($urandom(), 1'b0);
        push_word($urandom(), 1'b0);
        wait_results_drained();
        write_reg(crv_pkg::CFG_EXPECTED, $urandom());
        push_word($urandom(), 1'b1);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_words);
        int stop_at;
        int kind;
        int len;
        wait_results_drained();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        write_all_regs();
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            kind = $urandom_range(19);
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            if (kind < 2) begin
                wait_results_drained();
                write_reg(crv_pkg::CFG_IDX_W'($urandom_range((1 << crv_pkg::CFG_IDX_W) - 1)),
                          pick_cfg_value(crv_pkg::CFG_IDX_W'(
                              $urandom_range(int'(crv_pkg::CFG_LENGTH)))));
                send_region(len);
            end else if (kind == 2) begin
                send_matched_region(len);
            end else if (kind == 3) begin
                // abandon a region part-way; the write restarts the accumulator
                for (int i = 0; i < len; i++) begin
                    push_word($urandom(), 1'b0);
                end
                wait_results_drained();
                write_reg(crv_pkg::CFG_INIT, pick_cfg_value(crv_pkg::CFG_INIT));
            end else begin
                send_region(len);
            end
        end
    endtask

    task automatic test_output_backpressure();
        int stop_at;
        wait_results_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_reg(crv_pkg::CFG_FLASH, 32'h0000_1000);
        write_reg(crv_pkg::CFG_OFFSET, '0);
        write_reg(crv_pkg::CFG_LENGTH, 32'h0000_1000);
        sink_hold_left = 300;
        stop_at = words_sent + 40;
        while (words_sent < stop_at) begin
            send_region($urandom_range(3, 1));
        end
        wait_results_drained();
        sink_stall_pct = 50;
        stop_at = words_sent + 20;
        while (words_sent < stop_at) begin
            send_region($urandom_range(3, 1));
        end
    endtask

    always @(posedge aclk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left = sink_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        region_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (region_results_q.size() == 0) begin
                $error("result item with no region pending: tdata %h", m_tdata);
                error_count++;
            end else begin
                want = region_results_q.pop_front();
                if (m_tdata[crv_pkg::CRC_W-1:0] !== want.crc_value) begin
                    $error("crc_value: expected %h, got %h", want.crc_value,
                           m_tdata[crv_pkg::CRC_W-1:0]);
                    error_count++;
                end
                if (m_tdata[crv_pkg::CRC_W +: crv_pkg::STATUS_W] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_tdata[crv_pkg::CRC_W +: crv_pkg::STATUS_W]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cfg_shadow = '{crc_poly: crv_pkg::POLY_DEFAULT, crc_init: crv_pkg::INIT_DEFAULT,
                       expected_crc: '0, flash_size: '0, region_offset: '0,
                       region_length: '0};
        acc_shadow = crv_pkg::INIT_DEFAULT;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_region_bounds();
        test_crc_match();
        test_reload_rules();
        test_random_traffic(0, 0, 400);
        test_random_traffic(73, 0, 400);
        test_random_traffic(0, 73, 400);
        test_random_traffic(38, 38, 400);
        test_output_backpressure();
        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && region_results_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/crv_pkg.sv
rtl/crv_cfg_regs.sv
rtl/crv_col_gen.sv
rtl/crv_datapath.sv
rtl/crc32_region_verifier_unit.sv
bench/tb_top.sv
